// ----- hw/rtl/csp_pkg.sv -----
// ----------------------------------------------------------------------------
// csp_pkg
// Types, byte codes and helpers for the compass sentence parser.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int FRACTION_DIGITS = 1;
  localparam int FD_LIM          = (FRACTION_DIGITS > 3) ? 3 : FRACTION_DIGITS;

  localparam int VAL_W = 16;
  localparam int MAG_W = 19;
  localparam int CNT_W = 3;
  localparam int NUM_FIELDS = 4;

  localparam logic [MAG_W-1:0] MAG_CAP = {MAG_W{1'b1}};
  localparam logic [1:0]       FD_LIM_C = 2'(FD_LIM);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_PREFIX   = 8'b0000_0010,
    PH_YAW      = 8'b0000_0100,
    PH_PITCH    = 8'b0000_1000,
    PH_ROLL     = 8'b0001_0000,
    PH_TEMP     = 8'b0010_0000,
    PH_CHECKSUM = 8'b0100_0000,
    PH_STOPPED  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic err;
    logic digit;
    logic point;
    logic sign;
  } num_flags_t;

  function automatic logic [9:0] pow10(input logic [1:0] idx);
    logic [9:0] p;
    case (idx)
      2'd0:    p = 10'd1;
      2'd1:    p = 10'd10;
      2'd2:    p = 10'd100;
      default: p = 10'd1000;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/compass_sentence_parser.sv -----
// ----------------------------------------------------------------------------
// compass_sentence_parser
// Parses $..C<yaw>P<pitch>R<roll>T<temp>*<sum> CR sentences, one byte per
// transfer, into saturated signed tenths; one result per closing CR.
// ----------------------------------------------------------------------------
//  channel | ports                                   | dir | transfer
//  --------+-----------------------------------------+-----+--------------------
//  in      | in_valid in_ready in_rx_byte            | in  | in_valid & in_ready
//  out     | out_valid out_ready out_yaw/pitch/roll/ | out | out_valid & out_ready
//          | temp_tenths out_fields_updated          |     |
//
//  One byte per cycle. Each byte is parsed by one pass of logic on the
//  parser registers; a CR loads the output register and the result shows
//  the cycle after its transfer. in_ready = !out_valid | out_ready, so a
//  stalled result blocks input only while it is held. Synchronous reset
//  clears phase, number, held values and count; no clearing pass.
// ----------------------------------------------------------------------------
module compass_sentence_parser import csp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_yaw_tenths,
  output logic signed [VAL_W-1:0] out_pitch_tenths,
  output logic signed [VAL_W-1:0] out_roll_tenths,
  output logic signed [VAL_W-1:0] out_temp_tenths,
  output logic [CNT_W-1:0]        out_fields_updated
);

  phase_t             phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  num_flags_t         flg_r, flg_nxt;
  logic [1:0]         frac_r, frac_nxt;
  logic [VAL_W-1:0]   held_r [NUM_FIELDS];
  logic [VAL_W-1:0]   held_nxt [NUM_FIELDS];
  logic [CNT_W-1:0]   upd_r, upd_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]   out_val_r [NUM_FIELDS];
  logic [CNT_W-1:0]   out_cnt_r;

  logic               in_fire;
  logic               emit;
  logic [7:0]         b;

  // digit accumulate
  logic               is_digit;
  logic [3:0]         dval;
  logic [22:0]        acc_ext;
  logic [MAG_W-1:0]   acc_sat;

  // feed results
  logic               f_neg;
  logic [MAG_W-1:0]   f_mag;
  num_flags_t         f_flg;
  logic [1:0]         f_frac;

  // commit
  logic [28:0]        scaled;
  logic [VAL_W-1:0]   cvalue;
  logic [1:0]         fidx;
  logic [7:0]         fend;
  phase_t             fnext;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign b        = in_rx_byte;

  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dval     = 4'(b - CH_ZERO);
  assign acc_ext  = 23'(mag_r) * 23'd10 + 23'(dval);
  assign acc_sat  = (acc_ext > 23'(MAG_CAP)) ? MAG_CAP : acc_ext[MAG_W-1:0];

  always_comb begin
    f_neg  = neg_r;
    f_mag  = mag_r;
    f_flg  = flg_r;
    f_frac = frac_r;
    if (!flg_r.err) begin
      if (is_digit) begin
        f_flg.digit = 1'b1;
        if (flg_r.point) begin
          if (frac_r < FD_LIM_C) begin
            f_mag  = acc_sat;
            f_frac = frac_r + 2'd1;
          end
        end else begin
          f_mag = acc_sat;
        end
      end else if (b == CH_POINT) begin
        if (flg_r.point) f_flg.err = 1'b1;
        else             f_flg.point = 1'b1;
      end else if (b == CH_PLUS || b == CH_MINUS) begin
        if (flg_r.sign || flg_r.point || flg_r.digit) begin
          f_flg.err = 1'b1;
        end else begin
          f_flg.sign = 1'b1;
          if (b == CH_MINUS) f_neg = 1'b1;
        end
      end else begin
        f_flg.err = 1'b1;
      end
    end
  end

  assign scaled = 29'(mag_r) * 29'(pow10(FD_LIM_C - frac_r));

  always_comb begin
    if (neg_r) begin
      cvalue = (scaled > 29'd32768) ? 16'h8000 : 16'(17'h10000 - 17'(scaled));
    end else begin
      cvalue = (scaled > 29'd32767) ? 16'h7FFF : scaled[VAL_W-1:0];
    end
  end

  always_comb begin
    case (phase_r)
      PH_YAW:   begin fidx = 2'd0; fend = CH_P;    fnext = PH_PITCH;    end
      PH_PITCH: begin fidx = 2'd1; fend = CH_R;    fnext = PH_ROLL;     end
      PH_ROLL:  begin fidx = 2'd2; fend = CH_T;    fnext = PH_TEMP;     end
      PH_TEMP:  begin fidx = 2'd3; fend = CH_STAR; fnext = PH_CHECKSUM; end
      default:  begin fidx = 2'd0; fend = CH_P;    fnext = PH_STOPPED;  end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    flg_nxt   = flg_r;
    frac_nxt  = frac_r;
    upd_nxt   = upd_r;
    held_nxt  = held_r;
    emit      = 1'b0;
    if (in_fire) begin
      if (b == CH_DOLLAR) begin
        phase_nxt = PH_PREFIX;
        upd_nxt   = '0;
        neg_nxt   = 1'b0;
        mag_nxt   = '0;
        flg_nxt   = '0;
        frac_nxt  = '0;
      end else if (phase_r != PH_IDLE) begin
        if (b == CH_CR) begin
          emit      = 1'b1;
          phase_nxt = PH_IDLE;
          neg_nxt   = 1'b0;
          mag_nxt   = '0;
          flg_nxt   = '0;
          frac_nxt  = '0;
        end else begin
          case (phase_r)
            PH_PREFIX: begin
              if (b == CH_C) begin
                phase_nxt = PH_YAW;
                neg_nxt   = 1'b0;
                mag_nxt   = '0;
                flg_nxt   = '0;
                frac_nxt  = '0;
              end
            end
            PH_YAW, PH_PITCH, PH_ROLL, PH_TEMP: begin
              if (b == fend) begin
                if (flg_r.err || !flg_r.digit) begin
                  phase_nxt = PH_STOPPED;
                end else begin
                  held_nxt[fidx] = cvalue;
                  if (upd_r < CNT_W'(NUM_FIELDS)) upd_nxt = upd_r + CNT_W'(1);
                  neg_nxt   = 1'b0;
                  mag_nxt   = '0;
                  flg_nxt   = '0;
                  frac_nxt  = '0;
                  phase_nxt = fnext;
                end
              end else begin
                neg_nxt  = f_neg;
                mag_nxt  = f_mag;
                flg_nxt  = f_flg;
                frac_nxt = f_frac;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    if (emit)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      neg_r       <= 1'b0;
      mag_r       <= '0;
      flg_r       <= '0;
      frac_r      <= '0;
      upd_r       <= '0;
      held_r      <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      mag_r       <= mag_nxt;
      flg_r       <= flg_nxt;
      frac_r      <= frac_nxt;
      upd_r       <= upd_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_val_r <= held_r;
      out_cnt_r <= upd_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_yaw_tenths     = out_val_r[0];
  assign out_pitch_tenths   = out_val_r[1];
  assign out_roll_tenths    = out_val_r[2];
  assign out_temp_tenths    = out_val_r[3];
  assign out_fields_updated = out_cnt_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    upd_r <= CNT_W'(NUM_FIELDS))
    else $error("update count beyond field count");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    frac_r <= FD_LIM_C)
    else $error("fraction digit count beyond limit");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && in_rx_byte == CH_CR))
    else $error("result without a closing CR");

  a_dollar: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_rx_byte == CH_DOLLAR |=> phase_r == PH_PREFIX && upd_r == '0)
    else $error("dollar did not restart the sentence");

  a_out_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cnt_r <= CNT_W'(NUM_FIELDS))
    else $error("result count beyond field count");

endmodule
